/* sv/bpm_pkg.sv */
// Shared types and constants for the byte pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
package bpm_pkg;

    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int LEN_W             = 5;
    localparam int PATTERN_BYTES     = 16;
    localparam int OUT_POS_W         = 32;
    localparam int COUNT_W           = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = 1;
    localparam int QCNT_W            = 2;
    localparam int DEF_MAX_PATTERN   = 16;
    localparam int DEF_POSITION_BITS = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] bytes;
        logic [LEN_W-1:0]           length;
    } t_pattern;

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] start_position;
        logic                 is_end;
        logic [COUNT_W-1:0]   total_matches;
    } t_result;

endpackage
`default_nettype wire

/* sv/bpm_front.sv */
// Front end: byte window, fill/position/match counters and parallel pattern compare.
`timescale 1ns / 1ps
`default_nettype none
module bpm_front #(
    parameter int MAX_PATTERN   = bpm_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = bpm_pkg::DEF_POSITION_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    input  wire bpm_pkg::t_pattern i_pattern,
    input  wire logic              i_queue_full,
    output logic                   o_push,
    output bpm_pkg::t_result       o_result
);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = bpm_pkg::LEN_W;

    logic [7:0]                  r_window [MAX_PATTERN];
    logic [LEN_W-1:0]            r_fill;
    logic [POSITION_BITS-1:0]    r_pos;
    logic [bpm_pkg::COUNT_W-1:0] r_count;

    logic [7:0]                  w_new [MAX_PATTERN];
    logic [LEN_W-1:0]            len;
    logic [LEN_W-1:0]            fill_inc;
    logic [MAX_PATTERN-1:0]      cmp_ok;
    logic                        hit;
    logic                        accept;
    logic [bpm_pkg::COUNT_W-1:0] count_inc;
    logic [POSITION_BITS-1:0]    start_full;
    logic [POSITION_BITS+bpm_pkg::OUT_POS_W-1:0] start_ext;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // Window after this byte is shifted in, newest in entry 0
    always_comb begin
        w_new[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            w_new[k] = r_window[k-1];
        end
    end

    // Clamp the configured length into 1..MAX_PATTERN
    always_comb begin
        if (i_pattern.length == '0) begin
            len = LEN_W'(1);
        end else if (i_pattern.length > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = i_pattern.length;
        end
    end

    // Pattern byte g lines up with window entry len-1-g
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cmp
        logic [LEN_W-1:0] sel;
        assign sel = len - LEN_W'(g + 1);
        assign cmp_ok[g] = (LEN_W'(g) >= len) ||
                           (w_new[sel[IDX_W-1:0]] == i_pattern.bytes[g*8 +: 8]);
    end

    always_comb begin
        fill_inc = r_fill;
        if (r_fill < len) begin
            fill_inc = r_fill + LEN_W'(1);
        end
        if (fill_inc > len) begin
            fill_inc = len;
        end
    end

    assign hit       = (fill_inc >= len) && (&cmp_ok);
    assign count_inc = (hit && (r_count != '1)) ? r_count + bpm_pkg::COUNT_W'(1) : r_count;
    assign start_full = r_pos - POSITION_BITS'(len - LEN_W'(1));
    assign start_ext  = {bpm_pkg::OUT_POS_W'(0), start_full};

    assign o_push = accept && (hit || i_last_byte);

    always_comb begin
        o_result.found          = hit;
        o_result.start_position = hit ? start_ext[bpm_pkg::OUT_POS_W-1:0] : '0;
        o_result.is_end         = i_last_byte;
        o_result.total_matches  = count_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= '0;
            end
            r_fill  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_window <= w_new;
            // restart the fill after a match or at the end of the source
            r_fill   <= (hit || i_last_byte) ? '0 : fill_inc;
            if (i_last_byte) begin
                r_pos   <= '0;
                r_count <= '0;
            end else begin
                r_pos   <= (r_pos != '1) ? r_pos + POSITION_BITS'(1) : r_pos;
                r_count <= count_inc;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/bpm_queue.sv */
// Short result queue between the compare front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module bpm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bpm_pkg::t_result i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_not_empty,
    output bpm_pkg::t_result      o_data
);
    bpm_pkg::t_result               r_mem [bpm_pkg::QUEUE_DEPTH];
    logic [bpm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [bpm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [bpm_pkg::QCNT_W-1:0]     r_count;

    assign o_full      = (r_count == bpm_pkg::QCNT_W'(bpm_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bpm_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bpm_pkg::QPTR_W'(1);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + bpm_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - bpm_pkg::QCNT_W'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("result pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("result popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bpm_pkg::QCNT_W'(bpm_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pointer_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

/* sv/bpm_back.sv */
// Back end: output register that presents one result transaction at a time.
`timescale 1ns / 1ps
`default_nettype none
module bpm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_not_empty,
    input  wire bpm_pkg::t_result i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bpm_pkg::t_result      o_result
);
    logic             r_valid;
    bpm_pkg::t_result r_result;
    logic             n_valid;

    // Load a new result when the register is empty or being drained
    assign o_pop   = i_q_not_empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* sv/byte_pattern_matcher_unit.sv */
// Top level of the byte pattern matcher: configuration registers and the three stages.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one source byte per transaction,
//    with i_last_byte marking the final byte of a source.
//  - Output channel (o_out_valid / i_out_ready) carries a result transaction whenever
//    a match ends at a byte, or a byte is the last one (both may share one result).
//    Matches never overlap; the search restarts after the end of each match.
//  - Configuration is a plain write port: i_cfg_we, i_cfg_index, i_cfg_data. Index 0
//    and 1 load pattern bytes 0-7 and 8-15, index 2 the pattern length. Write only
//    while no transaction is in flight.
//  - Throughput: one byte per cycle while the queue has room. The window compare
//    of all pattern bytes runs in the accepting cycle, so the front end never iterates.
//  - Result path: a result enters the queue at the edge that accepts its byte, and
//    moves to the output register once that register is empty or being drained.
//  - Receiver stall: the output register holds, the two-entry queue absorbs results,
//    and o_in_ready drops only once the queue is full.
//  - Reset (synchronous, active low) clears the counters, window and queue, and sets
//    the pattern to all zero bytes with length one. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module byte_pattern_matcher_unit #(
    parameter int MAX_PATTERN   = bpm_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = bpm_pkg::DEF_POSITION_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // byte input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_last_byte,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_found,
    output logic [bpm_pkg::OUT_POS_W-1:0]         o_start_position,
    output logic                                  o_is_end,
    output logic [bpm_pkg::COUNT_W-1:0]           o_total_matches,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    logic [bpm_pkg::CFG_DATA_W-1:0] r_pattern_low;
    logic [bpm_pkg::CFG_DATA_W-1:0] r_pattern_high;
    logic [bpm_pkg::LEN_W-1:0]      r_pattern_length;

    bpm_pkg::t_pattern pattern;
    bpm_pkg::t_result  front_result;
    bpm_pkg::t_result  queue_data;
    bpm_pkg::t_result  out_result;
    logic              front_push;
    logic              queue_full;
    logic              queue_not_empty;
    logic              back_pop;

    // Configuration registers: write on enable, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= bpm_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpm_pkg::CFG_PATTERN_LOW: begin
                    r_pattern_low <= i_cfg_data;
                end
                bpm_pkg::CFG_PATTERN_HIGH: begin
                    r_pattern_high <= i_cfg_data;
                end
                bpm_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[bpm_pkg::LEN_W-1:0];
                end
                default: begin
                    r_pattern_low <= r_pattern_low;
                end
            endcase
        end
    end

    assign pattern.bytes  = {r_pattern_high, r_pattern_low};
    assign pattern.length = r_pattern_length;

    // Front end: shift, compare and count each accepted byte
    bpm_front #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_pattern    (pattern),
        .i_queue_full (queue_full),
        .o_push       (front_push),
        .o_result     (front_result)
    );

    // Queue decouples the front end from receiver stalls
    bpm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_data      (front_result),
        .o_full      (queue_full),
        .i_pop       (back_pop),
        .o_not_empty (queue_not_empty),
        .o_data      (queue_data)
    );

    // Back end: hold each result until the receiver takes it
    bpm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (queue_not_empty),
        .i_q_data      (queue_data),
        .o_pop         (back_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_result      (out_result)
    );

    assign o_found          = out_result.found;
    assign o_start_position = out_result.start_position;
    assign o_is_end         = out_result.is_end;
    assign o_total_matches  = out_result.total_matches;

endmodule
`default_nettype wire

/* sim/byte_pattern_matcher_unit_tb.sv */
// Self-checking testbench for the byte pattern matcher: directed table, then random streams.
`timescale 1ns / 1ps
module byte_pattern_matcher_unit_tb;
    import bpm_pkg::*;

    localparam int                   MAX_PATTERN      = DEF_MAX_PATTERN;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int                   MAX_REPORTS      = 40;
    localparam int                   RANDOM_PHASES    = 15;
    localparam int                   PHASE_BYTES      = 100;
    localparam int                   LONG_HOLD        = 300;

    typedef enum logic { ROW_CFG, ROW_BYTE } t_row_kind;
    typedef enum logic { CHK_PRED, CHK_TYPED } t_row_check;

    // One row of the directed table: a register write or a source byte
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [7:0]            data_byte;
        logic                  last;
        t_row_check            chk;
        t_result               res;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [OUT_POS_W-1:0]  o_start_position;
    logic                  o_is_end;
    logic [COUNT_W-1:0]    o_total_matches;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Matcher copy: pattern registers and search state as seen after reset
    logic [63:0]          pat_low  = '0;
    logic [63:0]          pat_high = '0;
    logic [LEN_W-1:0]     pat_len  = 5'd1;
    logic [7:0]           win [PATTERN_BYTES];
    int                   fill     = 0;
    logic [OUT_POS_W-1:0] pos      = '0;
    logic [COUNT_W-1:0]   hits     = '0;

    t_result pending_results [$];
    t_row    dir_rows [$];
    int      mismatch_count = 0;
    int      tx_gap_max     = 14;
    int      rx_wait_max    = 14;
    bit      rx_hold_req    = 1'b0;

    byte_pattern_matcher_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_start_position (o_start_position),
        .o_is_end         (o_is_end),
        .o_total_matches  (o_total_matches),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Clamp the programmed length: zero acts as one, anything past the window as the window
    function automatic int eff_len();
        int n;
        n = int'(pat_len);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        if (i < 8) return pat_low[8*i +: 8];
        return pat_high[8*(i-8) +: 8];
    endfunction

    // Advance the matcher copy by one source byte; has tells whether a result is due
    function automatic void scan_byte(input logic [7:0] b, input logic l,
                                      output bit has, output t_result r);
        int                   len;
        bit                   hit;
        logic [OUT_POS_W-1:0] start;
        len = eff_len();
        for (int i = PATTERN_BYTES - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (fill < len) fill++;
        if (fill > len) fill = len;
        hit = 1'b0;
        if (fill >= len) begin
            hit = 1'b1;
            // newest byte sits in entry 0, so pattern byte 0 lines up with entry len-1
            for (int i = 0; i < len; i++) begin
                if (win[len-1-i] != pat_byte(i)) hit = 1'b0;
            end
        end
        start = '0;
        if (hit) begin
            start = pos - 32'(len - 1);
            fill  = 0;  // restart the search after the match, no overlap
            if (hits != '1) hits++;
        end
        if (pos != '1) pos++;
        has              = hit || l;
        r.found          = hit;
        r.start_position = start;
        r.is_end         = l;
        r.total_matches  = hits;
        if (l) begin
            fill = 0;
            pos  = '0;
            hits = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_row blank_row();
        t_row row;
        row.kind      = ROW_BYTE;
        row.idx       = '0;
        row.data      = '0;
        row.data_byte = '0;
        row.last      = 1'b0;
        row.chk       = CHK_PRED;
        row.res       = '0;
        return row;
    endfunction

    function automatic void tab_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row           = blank_row();
        row.kind      = ROW_CFG;
        row.idx       = idx;
        row.data      = data;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void tab_byte(input logic [7:0] b, input logic l);
        t_row row;
        row           = blank_row();
        row.kind      = ROW_BYTE;
        row.data_byte = b;
        row.last      = l;
        row.chk       = CHK_PRED;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void tab_typed(input logic [7:0] b, input logic l, input logic f,
                                      input logic [31:0] start, input logic e,
                                      input logic [31:0] total);
        t_row row;
        row                    = blank_row();
        row.kind               = ROW_BYTE;
        row.data_byte          = b;
        row.last               = l;
        row.chk                = CHK_TYPED;
        row.res.found          = f;
        row.res.start_position = start;
        row.res.is_end         = e;
        row.res.total_matches  = total;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Offer one byte, hold it until the transaction completes, then queue what it should yield
    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input t_result want);
        int      gap;
        bit      has;
        t_result pred;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_in_ready);
        scan_byte(b, l, has, pred);
        if (typed) pending_results.insert(pending_results.size(), want);
        else if (has) pending_results.insert(pending_results.size(), pred);
    endtask

    // Drop valid and wait until every queued result is out, then let the pipe settle
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; the enable is dropped again before the task returns
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:    pat_low  = data;
            CFG_PATTERN_HIGH:   pat_high = data;
            CFG_PATTERN_LENGTH: pat_len  = data[LEN_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: draw a wait per transaction, honor a long hold-off on request,
    // and compare every accepted result with the oldest expectation
    initial begin : result_sink
        int      w;
        t_result want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                w = LONG_HOLD;
            end else begin
                w = $urandom_range(0, rx_wait_max);
            end
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found got %0b expected %0b",
                                              o_found, want.found));
                if (o_start_position !== want.start_position)
                    report_mismatch($sformatf("start_position got %0d expected %0d",
                                              o_start_position, want.start_position));
                if (o_is_end !== want.is_end)
                    report_mismatch($sformatf("is_end got %0b expected %0b",
                                              o_is_end, want.is_end));
                if (o_total_matches !== want.total_matches)
                    report_mismatch($sformatf("total_matches got %0d expected %0d",
                                              o_total_matches, want.total_matches));
            end
        end
    end

    // Source side: reset, directed table, then random phases with a new pattern each
    initial begin : byte_source
        int               phase;
        int               sent;
        int               r;
        int               n;
        int               plen;
        bit               prev_byte;
        logic [7:0]       chunk [$];
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      len_data;
        logic [LEN_W-1:0] len5;
        logic [7:0]       sym0;
        logic [7:0]       sym1;
        logic             l;
        for (int k = 0; k < PATTERN_BYTES; k++) win[k] = '0;

        // Reset pattern is one zero byte: a zero byte hits at once
        tab_typed(8'h00, 1'b0, 1'b1, 32'd0, 1'b0, 32'd1);
        tab_typed(8'hFF, 1'b1, 1'b0, 32'd0, 1'b1, 32'd1);
        // Fresh source after the end: hit and end share one result
        tab_typed(8'h00, 1'b1, 1'b1, 32'd0, 1'b1, 32'd1);
        // Length zero acts as one
        tab_cfg(CFG_PATTERN_LOW, 64'h0000_0000_0000_0041);
        tab_cfg(CFG_PATTERN_LENGTH, 64'd0);
        tab_typed(8'h41, 1'b0, 1'b1, 32'd0, 1'b0, 32'd1);
        tab_typed(8'h42, 1'b1, 1'b0, 32'd0, 1'b1, 32'd1);
        // Full window of alternating extremes, matched by the last byte of the source
        tab_cfg(CFG_PATTERN_LOW, 64'hFF00_FF00_FF00_FF00);
        tab_cfg(CFG_PATTERN_HIGH, 64'hFF00_FF00_FF00_FF00);
        tab_cfg(CFG_PATTERN_LENGTH, 64'd16);
        for (int k = 0; k < 15; k++) tab_byte((k % 2 == 0) ? 8'h00 : 8'hFF, 1'b0);
        tab_typed(8'hFF, 1'b1, 1'b1, 32'd0, 1'b1, 32'd1);
        // Oversized length clamps to the window; a short source never matches
        tab_cfg(CFG_PATTERN_LENGTH, 64'd31);
        tab_byte(8'h00, 1'b0);
        tab_byte(8'hFF, 1'b0);
        tab_typed(8'h00, 1'b1, 1'b0, 32'd0, 1'b1, 32'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; drain before any write so the block is idle
        prev_byte = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                if (prev_byte) drain_pipe();
                cfg_write(dir_rows[k].idx, dir_rows[k].data);
                prev_byte = 1'b0;
            end else begin
                send_byte(dir_rows[k].data_byte, dir_rows[k].last,
                          dir_rows[k].chk == CHK_TYPED, dir_rows[k].res);
                prev_byte = 1'b1;
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipe();

            // Pick a length: the clamped corners now and then, mostly short patterns
            r = $urandom_range(0, 9);
            case (r)
                0:       len5 = 5'd0;
                1:       len5 = 5'd1;
                2:       len5 = 5'd16;
                3:       len5 = 5'($urandom_range(17, 31));
                default: len5 = 5'($urandom_range(2, 6));
            endcase
            if (phase == 1) len5 = 5'd1;  // every hit makes a result: fills the queue fast
            len_data = '0;
            if ($urandom_range(0, 3) == 0) len_data = {$urandom, $urandom};  // junk above
            len_data[LEN_W-1:0] = len5;

            // Pattern bytes: fully random, or two symbols so near-misses overlap
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 1) begin
                sym0 = 8'($urandom);
                sym1 = 8'($urandom);
                for (int k = 0; k < 8; k++) begin
                    lo[8*k +: 8] = ($urandom_range(0, 1) == 1) ? sym0 : sym1;
                    hi[8*k +: 8] = ($urandom_range(0, 1) == 1) ? sym0 : sym1;
                end
            end
            cfg_write(CFG_PATTERN_LOW, lo);
            cfg_write(CFG_PATTERN_HIGH, hi);
            cfg_write(CFG_PATTERN_LENGTH, len_data);
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED_INDEX, {$urandom, $urandom});

            // Vary pacing per phase: bursts with no idling on one or both sides
            tx_gap_max  = (phase % 4 == 3 || phase % 6 == 5) ? 0 : 14;
            rx_wait_max = (phase % 4 == 3 || phase % 5 == 2) ? 0 : 14;
            if (phase == 1) rx_hold_req = 1'b1;

            plen = eff_len();
            sent = 0;
            while (sent < PHASE_BYTES) begin
                chunk.delete();
                r = $urandom_range(0, 15);
                if (r <= 8) begin
                    // whole pattern, one in nine with a corrupted byte
                    for (int k = 0; k < plen; k++) chunk.insert(chunk.size(), pat_byte(k));
                    if (r == 8) chunk[$urandom_range(0, plen - 1)] = 8'($urandom);
                end else if (r <= 11) begin
                    // broken-off prefix
                    n = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                    for (int k = 0; k < n; k++) chunk.insert(chunk.size(), pat_byte(k));
                end else begin
                    // filler: pattern symbols or any byte
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                        chunk.insert(chunk.size(),
                                     (r <= 13) ? pat_byte($urandom_range(0, plen - 1))
                                               : 8'($urandom));
                end
                foreach (chunk[k]) begin
                    l = ($urandom_range(0, 39) == 0);
                    send_byte(chunk[k], l, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_pipe();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
